>>> rtl/great_circle_distance_defines.svh
// Assertion shorthands for the RTL
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define GCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("great_circle_distance: check failed");

// next-cycle implication
`define GCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("great_circle_distance: check failed");

`endif

>>> rtl/gcd_pkg.sv
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 22;

    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam int SQRT_STEPS   = 32;
    localparam int SQRT_W       = 63;

    // atan(2^-i) as binary angle, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340246, 32'd2670164, 32'd1335088,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [30:0] ONE_Q30         = 31'd1073741824;
    localparam logic [31:0] PI_Q30          = 32'd3373259426;
    localparam logic [12:0] EARTH_RADIUS_KM = 13'd6371;

    // floor(x/45) = (x * M) >> S, exact over the stated input range
    localparam logic [32:0] DIV45_M1 = 33'd6108397933;  // x < 2^32, S = 38
    localparam int          DIV45_S1 = 38;
    localparam logic [19:0] DIV45_M2 = 20'd745655;      // x < 2^19, S = 25
    localparam int          DIV45_S2 = 25;

endpackage

>>> rtl/gcd_cordic.sv
module gcd_cordic
    import gcd_pkg::*;
#(
    parameter bit VECTOR = 1'b0
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic                       flip_in,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic signed [CORDIC_W-1:0] z_in,
    output logic                       valid_out,
    output logic signed [CORDIC_W-1:0] x_out,
    output logic signed [CORDIC_W-1:0] y_out,
    output logic signed [CORDIC_W-1:0] z_out
);

    localparam int LAST = CORDIC_STEPS - 1;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0]    flip_reg;
    logic [CORDIC_STEPS-1:0]    valid_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [CORDIC_W-1:0] xs, ys, zs, dx, dy, at;
        logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
        logic                       fs, vs, ccw;

        if (i == 0) begin : g_first
            assign xs = x_in;
            assign ys = y_in;
            assign zs = z_in;
            assign fs = flip_in;
            assign vs = valid_in;
        end else begin : g_rest
            assign xs = x_reg[i-1];
            assign ys = y_reg[i-1];
            assign zs = z_reg[i-1];
            assign fs = flip_reg[i-1];
            assign vs = valid_reg[i-1];
        end

        assign at = $signed({{(CORDIC_W-32){1'b0}}, ATAN_TURNS[i]});

        always_comb
        begin
            dx  = ys >>> i;
            dy  = xs >>> i;
            // rotation drives z to zero, vectoring drives y to zero
            ccw = VECTOR ? (ys <= 0) : (zs >= 0);
            if (ccw)
            begin
                x_next = xs - dx;
                y_next = ys + dy;
                z_next = zs - at;
            end
            else
            begin
                x_next = xs + dx;
                y_next = ys - dy;
                z_next = zs + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                flip_reg[i] <= fs;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= vs;
        end
    end

    assign valid_out = valid_reg[LAST];
    assign x_out     = flip_reg[LAST] ? -x_reg[LAST] : x_reg[LAST];
    assign y_out     = flip_reg[LAST] ? -y_reg[LAST] : y_reg[LAST];
    assign z_out     = z_reg[LAST];

endmodule

>>> rtl/gcd_isqrt.sv
module gcd_isqrt
    import gcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [SQRT_W-1:0] n_in,
    output logic              valid_out,
    output logic [30:0]       root
);

    localparam int LAST = SQRT_STEPS - 1;

    logic [SQRT_W-1:0]     n_reg [SQRT_STEPS];
    logic [SQRT_W-1:0]     r_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] valid_reg;

    // one result bit per stage, restoring form
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 1 - 2 * i);
        logic [SQRT_W-1:0] ns, rs, trial, n_next, r_next;
        logic              vs;

        if (i == 0) begin : g_first
            assign ns = n_in;
            assign rs = '0;
            assign vs = valid_in;
        end else begin : g_rest
            assign ns = n_reg[i-1];
            assign rs = r_reg[i-1];
            assign vs = valid_reg[i-1];
        end

        always_comb
        begin
            trial = rs + BIT;
            if (ns >= trial)
            begin
                n_next = ns - trial;
                r_next = (rs >> 1) + BIT;
            end
            else
            begin
                n_next = ns;
                r_next = rs >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i] <= n_next;
                r_reg[i] <= r_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= vs;
        end
    end

    assign valid_out = valid_reg[LAST];
    assign root      = r_reg[LAST][30:0];

endmodule

>>> rtl/great_circle_distance.sv
// Haversine distance, fully pipelined: one point pair per cycle when the output is taken.
// The path from the input transfer to the earliest result transfer runs through the
// two 30-step CORDIC chains and the 32-step square root chain, plus 13 stages of conversion,
// products and output. A two-entry output (register plus skid) lets input continue while a result waits.
// rst_n is asynchronous, active low; it clears every valid bit, data registers keep garbage.
`include "great_circle_distance_defines.svh"

module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [30:0] lon_a,
    input  logic signed [29:0] lat_a,
    input  logic signed [30:0] lon_b,
    input  logic signed [29:0] lat_b,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [30:0]        distance
);

    localparam int NL      = 4;
    // deg * 2^(32-F) / 720 = (deg << SH_HALF) / 45, likewise for 360
    localparam int SH_HALF = 32 - ANGLE_FRAC_BITS - 4;
    localparam int SH_FULL = 32 - ANGLE_FRAC_BITS - 3;

    logic en;

    // output register with skid entry; the pipe freezes while the skid is full
    logic        out_valid_reg, skid_valid_reg;
    logic [30:0] out_data_reg, skid_data_reg;

    // front: angle to binary angle, lanes are dlat/2, dlon/2, lat_a, lat_b
    logic [6:0]                 front_vld_reg;
    logic signed [32:0]         v1_next [NL];
    logic signed [32:0]         v1_reg [NL];
    logic [31:0]                mag2_reg [NL];
    logic [NL-1:0]              neg2_reg, neg3_reg, neg4_reg, neg5_reg, flip7_reg;
    logic [31:0]                mag3_reg [NL];
    logic [26:0]                q3_reg [NL];
    logic [26:0]                q4_reg [NL];
    logic [5:0]                 rem4_reg [NL];
    logic [26:0]                q5_reg [NL];
    logic [13:0]                frac5_reg [NL];
    logic [31:0]                turns6_reg [NL];
    logic signed [CORDIC_W-1:0] z7_reg [NL];

    logic                       rot_valid [NL];
    logic signed [CORDIC_W-1:0] cos_w [NL];
    logic signed [CORDIC_W-1:0] sin_w [NL];

    assign en         = !skid_valid_reg;
    assign item_ready = en;

    assign v1_next[0] = 33'(lat_b) - 33'(lat_a);
    assign v1_next[1] = 33'(lon_b) - 33'(lon_a);
    assign v1_next[2] = 33'(lat_a);
    assign v1_next[3] = 33'(lat_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_vld_reg <= '0;
        else if (en)
            front_vld_reg <= {front_vld_reg[5:0], item_valid};
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
        localparam int SH = (l < 2) ? SH_HALF : SH_FULL;
        logic [31:0] mag2_next;
        logic [64:0] prod3;
        logic [31:0] rem4_full;
        logic [18:0] u5;
        logic [38:0] prod5;
        logic [31:0] mag6, turns6_next, wrap7;
        logic        flip7_next;

        assign mag2_next   = v1_reg[l][32] ? 32'(-v1_reg[l]) : 32'(v1_reg[l]);
        assign prod3       = 65'(mag2_reg[l]) * 65'(DIV45_M1);
        assign rem4_full   = mag3_reg[l] - 32'(q3_reg[l]) * 32'd45;
        assign u5          = 19'(rem4_reg[l]) << SH;
        assign prod5       = 39'(u5) * 39'(DIV45_M2);
        assign mag6        = (32'(q5_reg[l]) << SH) | 32'(frac5_reg[l]);
        assign turns6_next = neg5_reg[l] ? -mag6 : mag6;
        // fold the angle into the right half plane, negate sin and cos at the end
        assign wrap7       = turns6_reg[l] + 32'h4000_0000;
        assign flip7_next  = wrap7[31];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v1_reg[l]     <= v1_next[l];
                mag2_reg[l]   <= mag2_next;
                neg2_reg[l]   <= v1_reg[l][32];
                mag3_reg[l]   <= mag2_reg[l];
                q3_reg[l]     <= prod3[DIV45_S1+26:DIV45_S1];
                neg3_reg[l]   <= neg2_reg[l];
                rem4_reg[l]   <= rem4_full[5:0];
                q4_reg[l]     <= q3_reg[l];
                neg4_reg[l]   <= neg3_reg[l];
                frac5_reg[l]  <= prod5[DIV45_S2+13:DIV45_S2];
                q5_reg[l]     <= q4_reg[l];
                neg5_reg[l]   <= neg4_reg[l];
                turns6_reg[l] <= turns6_next;
                flip7_reg[l]  <= flip7_next;
                z7_reg[l]     <= CORDIC_W'(signed'(flip7_next ? turns6_reg[l] + 32'h8000_0000
                                                              : turns6_reg[l]));
            end
        end

        gcd_cordic #(
            .VECTOR (1'b0)
        ) u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (front_vld_reg[6]),
            .flip_in   (flip7_reg[l]),
            .x_in      ($signed({{(CORDIC_W-30){1'b0}}, CORDIC_GAIN_Q30})),
            .y_in      ('0),
            .z_in      (z7_reg[l]),
            .valid_out (rot_valid[l]),
            .x_out     (cos_w[l]),
            .y_out     (sin_w[l]),
            .z_out     ()
        );
    end

    // products toward the haversine term a
    logic [2:0]         mid_vld_reg;
    logic signed [31:0] sd, sl, c1, c2;
    logic signed [63:0] pcc, psd, psl, pt;
    logic signed [31:0] cc8_reg, sd2_8_reg, sl2_8_reg, t9_reg, sd2_9_reg;
    logic signed [32:0] a_sum;
    logic [30:0]        a10_next, a10_reg;

    assign sd  = 32'(sin_w[0]);
    assign sl  = 32'(sin_w[1]);
    assign c1  = 32'(cos_w[2]);
    assign c2  = 32'(cos_w[3]);
    assign pcc = 64'(c1) * 64'(c2);
    assign psd = 64'(sd) * 64'(sd);
    assign psl = 64'(sl) * 64'(sl);
    assign pt  = 64'(cc8_reg) * 64'(sl2_8_reg);

    assign a_sum = 33'(sd2_9_reg) + 33'(t9_reg);

    always_comb
    begin
        if (a_sum < 0)
            a10_next = '0;
        else if (a_sum > 33'(ONE_Q30))
            a10_next = ONE_Q30;
        else
            a10_next = 31'(a_sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc8_reg   <= 32'(pcc >>> 30);
            sd2_8_reg <= 32'(psd >>> 30);
            sl2_8_reg <= 32'(psl >>> 30);
            t9_reg    <= 32'(pt >>> 30);
            sd2_9_reg <= sd2_8_reg;
            a10_reg   <= a10_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_vld_reg <= '0;
        else if (en)
            mid_vld_reg <= {mid_vld_reg[1:0], rot_valid[0]};
    end

    // sqrt(a), sqrt(1-a), then atan2 by vectoring
    logic        sq_valid;
    logic [30:0] ry, rx;

    gcd_isqrt u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mid_vld_reg[2]),
        .n_in      (SQRT_W'({a10_reg, 30'b0})),
        .valid_out (sq_valid),
        .root      (ry)
    );

    gcd_isqrt u_sqrt_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mid_vld_reg[2]),
        .n_in      (SQRT_W'({ONE_Q30 - a10_reg, 30'b0})),
        .valid_out (),
        .root      (rx)
    );

    logic                       at_valid;
    logic signed [CORDIC_W-1:0] theta_w;

    gcd_cordic #(
        .VECTOR (1'b1)
    ) u_atan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sq_valid),
        .flip_in   (1'b0),
        .x_in      ($signed(CORDIC_W'(rx))),
        .y_in      ($signed(CORDIC_W'(ry))),
        .z_in      ('0),
        .valid_out (at_valid),
        .x_out     (),
        .y_out     (),
        .z_out     (theta_w)
    );

    // angle to radians to kilometres
    logic [1:0]  tail_vld_reg;
    logic [30:0] theta11_next, theta11_reg;
    logic [62:0] prad;
    logic [31:0] rad12_reg;
    logic [44:0] pdist;
    logic [30:0] dist_w;

    always_comb
    begin
        if (theta_w < 0)
            theta11_next = '0;
        else if (theta_w > CORDIC_W'(ONE_Q30))
            theta11_next = ONE_Q30;
        else
            theta11_next = 31'(theta_w);
    end

    assign prad   = 63'(theta11_reg) * 63'(PI_Q30) + (63'(1) << 29);
    assign pdist  = 45'(rad12_reg) * 45'(EARTH_RADIUS_KM) + (45'(1) << 13);
    assign dist_w = pdist[44:14];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta11_reg <= theta11_next;
            rad12_reg   <= 32'(prad >> 30);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_vld_reg <= '0;
        else if (en)
            tail_vld_reg <= {tail_vld_reg[0], at_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
            out_valid_reg <= tail_vld_reg[1];
        else if (tail_vld_reg[1])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result_ready)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || result_ready)
            out_data_reg <= dist_w;
        else
            skid_data_reg <= dist_w;
    end

    assign result_valid = out_valid_reg;
    assign distance     = out_data_reg;

    `GCD_ASSERT_IMPL(a_skid_implies_out, skid_valid_reg, out_valid_reg)
    `GCD_ASSERT_NEXT(a_skid_drains, skid_valid_reg && result_ready, !skid_valid_reg)
    `GCD_ASSERT_IMPL(a_term_clamped, mid_vld_reg[2], a10_reg <= ONE_Q30)
    `GCD_ASSERT_IMPL(a_dist_bound, result_valid, distance <= 31'd1311710000)

endmodule
